FILE: src/lphs_pkg.sv
// Package for the linear probe hash set: op and status codes, and the
// command and status structs between controller and datapath. No dependencies.
package lphs_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_TEST  = 3'd1;
    localparam logic [2:0] OP_REM   = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [1:0] RS_DONE = 2'd0;
    localparam logic [1:0] RS_UPD  = 2'd1;
    localparam logic [1:0] RS_MISS = 2'd2;
    localparam logic [1:0] RS_FULL = 2'd3;

    typedef struct packed {
        logic       load;        // capture input word
        logic       idx_home;    // idx <= home slot of probe hash, probe count <= 0
        logic       idx_inc;     // step to the next slot
        logic       idx_zero;
        logic       probe_ord;   // probe key/hash <= order entry, idx <= its home
        logic       slot_wr_new; // write probe key into slot idx
        logic       slot_wr_clr; // write empty slot at idx
        logic       rd_pos;      // order read address from position, else rebuild index
        logic       ord_wr;      // append probe key to the order list
        logic       cnt_inc;
        logic       cnt_zero;
        logic       n_load;      // rebuild length <= count
        logic       ord_inc;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_found;
        logic       res_kout;    // result key from order read data
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       used;
        logic       match;
        logic       bound;
        logic       idx_last;
        logic       full;
        logic       pos_ok;
        logic       ord_done;
        logic       ord_is_key;
    } t_stat;

endpackage

FILE: src/lphs_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module lphs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/lphs_dp.sv
// Datapath of the hash set: slot and order RAMs, probe registers, counters
// and result registers. Depends on lphs_pkg and lphs_ram.
module lphs_dp #(
    parameter int SLOTS    = 64,
    parameter int KEY_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lphs_pkg::t_cmd i_cmd,
    output lphs_pkg::t_stat o_stat,
    input  logic [2:0]     i_op,
    input  logic [31:0]    i_key,
    input  logic [31:0]    i_hash,
    input  logic [5:0]     i_pos,
    output logic [1:0]     o_status,
    output logic           o_found,
    output logic [31:0]    o_key_out,
    output logic [5:0]     o_count
);
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = AW + 1;
    localparam int PX    = (CW > 6) ? CW : 6;
    localparam int LIMIT = 3 * SLOTS / 4;
    localparam logic [31:0] KMASK =
        (KEY_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << KEY_BITS) - 64'd1);

    logic [2:0]    r_op;
    logic [31:0]   r_key;
    logic [5:0]    r_pos;
    logic [31:0]   r_pk;
    logic [31:0]   r_ph;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_pcnt;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_ord;
    logic [1:0]    r_rstat;
    logic          r_rfound;
    logic [31:0]   r_rkout;
    logic [1:0]    r_ostat;
    logic          r_ofound;
    logic [31:0]   r_okout;
    logic [5:0]    r_ocount;

    logic [64:0]   slot_rdata;
    logic [64:0]   slot_wdata;
    logic [63:0]   ord_rdata;
    logic [AW-1:0] ord_raddr;
    logic [PX-1:0] pos_x;
    logic [PX-1:0] cnt_x;

    assign pos_x      = PX'(r_pos);
    assign cnt_x      = PX'(r_count);
    assign ord_raddr  = i_cmd.rd_pos ? pos_x[AW-1:0] : r_ord[AW-1:0];
    assign slot_wdata = i_cmd.slot_wr_new ? {1'b1, r_ph, r_pk} : '0;

    lphs_ram #(.WIDTH(65), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.slot_wr_new | i_cmd.slot_wr_clr),
        .i_waddr (r_idx),
        .i_wdata (slot_wdata),
        .i_raddr (r_idx),
        .o_rdata (slot_rdata)
    );

    lphs_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ord_wr),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_ph, r_pk}),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    always_comb begin
        o_stat.op         = r_op;
        o_stat.used       = slot_rdata[64];
        o_stat.match      = (slot_rdata[63:32] == r_ph) && (slot_rdata[31:0] == r_pk);
        o_stat.bound      = (r_pcnt == AW'(SLOTS - 1));
        o_stat.idx_last   = (r_idx == AW'(SLOTS - 1));
        o_stat.full       = (r_count >= CW'(LIMIT));
        o_stat.pos_ok     = (pos_x < cnt_x);
        o_stat.ord_done   = (r_ord == r_n);
        o_stat.ord_is_key = (ord_rdata[31:0] == r_key);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.idx_home) begin
                r_idx <= r_ph[AW-1:0];
            end else if (i_cmd.probe_ord) begin
                r_idx <= ord_rdata[32 +: AW];
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.cnt_zero) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= i_key & KMASK;
            r_pk  <= i_key & KMASK;
            r_ph  <= i_hash;
            r_pos <= i_pos;
        end else if (i_cmd.probe_ord) begin
            r_pk <= ord_rdata[31:0];
            r_ph <= ord_rdata[63:32];
        end
        if (i_cmd.idx_home || i_cmd.probe_ord) begin
            r_pcnt <= '0;
        end else if (i_cmd.idx_inc) begin
            r_pcnt <= r_pcnt + 1'b1;
        end
        if (i_cmd.n_load) begin
            r_n   <= r_count;
            r_ord <= '0;
        end else if (i_cmd.ord_inc) begin
            r_ord <= r_ord + 1'b1;
        end
        if (i_cmd.res_set) begin
            r_rstat  <= i_cmd.res_status;
            r_rfound <= i_cmd.res_found;
            r_rkout  <= i_cmd.res_kout ? ord_rdata[31:0] : '0;
        end
        if (i_cmd.out_load) begin
            r_ostat  <= r_rstat;
            r_ofound <= r_rfound;
            r_okout  <= r_rkout;
            r_ocount <= cnt_x[5:0];
        end
    end

    assign o_status  = r_ostat;
    assign o_found   = r_ofound;
    assign o_key_out = r_okout;
    assign o_count   = r_ocount;
endmodule

FILE: src/lphs_ctrl.sv
// Controller of the hash set: sequences probes, clearing passes and the
// remove rebuild. Depends on lphs_pkg.
module lphs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  lphs_pkg::t_stat i_stat,
    output lphs_pkg::t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DISP, S_P_RD, S_P_CHK, S_R_RD, S_R_CHK,
        S_I_RD, S_I_CHK, S_O_CHK, S_FIN
    } t_state;
    typedef enum logic [1:0] {AF_IDLE, AF_FIN, AF_REB} t_after;

    t_state r_state, n_state;
    t_after r_after, n_after;
    logic   r_m_valid, n_m_valid;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_after   = r_after;
        n_m_valid = r_m_valid;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_CLR: begin
                o_cmd.slot_wr_clr = 1'b1;
                if (i_stat.idx_last) begin
                    case (r_after)
                        AF_FIN:  n_state = S_FIN;
                        AF_REB:  n_state = S_R_RD;
                        default: n_state = S_IDLE;
                    endcase
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.res_set    = 1'b1;
                o_cmd.res_status = lphs_pkg::RS_MISS;
                n_state          = S_FIN;
                case (i_stat.op)
                    lphs_pkg::OP_ADD, lphs_pkg::OP_TEST, lphs_pkg::OP_REM: begin
                        o_cmd.idx_home = 1'b1;
                        n_state        = S_P_RD;
                    end
                    lphs_pkg::OP_READ: begin
                        o_cmd.rd_pos = 1'b1;
                        if (i_stat.pos_ok) begin
                            n_state = S_O_CHK;
                        end
                    end
                    lphs_pkg::OP_CLEAR: begin
                        o_cmd.res_status = lphs_pkg::RS_DONE;
                        o_cmd.idx_zero   = 1'b1;
                        o_cmd.cnt_zero   = 1'b1;
                        n_after          = AF_FIN;
                        n_state          = S_CLR;
                    end
                    default: ;
                endcase
            end
            S_P_RD: n_state = S_P_CHK;
            S_P_CHK: begin
                if (i_stat.used && i_stat.match) begin
                    o_cmd.res_set   = 1'b1;
                    o_cmd.res_found = 1'b1;
                    n_state         = S_FIN;
                    case (i_stat.op)
                        lphs_pkg::OP_ADD: o_cmd.res_status = lphs_pkg::RS_UPD;
                        lphs_pkg::OP_REM: begin
                            o_cmd.n_load   = 1'b1;
                            o_cmd.cnt_zero = 1'b1;
                            o_cmd.idx_zero = 1'b1;
                            n_after        = AF_REB;
                            n_state        = S_CLR;
                        end
                        default: o_cmd.res_status = lphs_pkg::RS_DONE;
                    endcase
                end else if (!i_stat.used || i_stat.bound) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = lphs_pkg::RS_MISS;
                    n_state          = S_FIN;
                    if (i_stat.op == lphs_pkg::OP_ADD) begin
                        if (i_stat.full) begin
                            o_cmd.res_status = lphs_pkg::RS_FULL;
                        end else begin
                            o_cmd.res_status  = lphs_pkg::RS_DONE;
                            o_cmd.slot_wr_new = !i_stat.used;
                            o_cmd.ord_wr      = !i_stat.used;
                            o_cmd.cnt_inc     = !i_stat.used;
                        end
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_P_RD;
                end
            end
            S_R_RD: begin
                if (i_stat.ord_done) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_R_CHK;
                end
            end
            S_R_CHK: begin
                if (i_stat.ord_is_key) begin
                    o_cmd.ord_inc = 1'b1;
                    n_state       = S_R_RD;
                end else begin
                    o_cmd.probe_ord = 1'b1;
                    n_state         = S_I_RD;
                end
            end
            S_I_RD: n_state = S_I_CHK;
            S_I_CHK: begin
                if (!i_stat.used || i_stat.bound) begin
                    // place at the first free slot, then take the next order entry
                    o_cmd.slot_wr_new = !i_stat.used;
                    o_cmd.ord_wr      = !i_stat.used;
                    o_cmd.cnt_inc     = !i_stat.used;
                    o_cmd.ord_inc     = 1'b1;
                    n_state           = S_R_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_I_RD;
                end
            end
            S_O_CHK: begin
                o_cmd.res_set    = 1'b1;
                o_cmd.res_status = lphs_pkg::RS_DONE;
                o_cmd.res_found  = 1'b1;
                o_cmd.res_kout   = 1'b1;
                n_state          = S_FIN;
            end
            S_FIN: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_after   <= AF_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_after   <= n_after;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
endmodule

FILE: src/linear_probe_hash_set_core.sv
// Channel  | dir | handshake            | payload
// s (ops)  | in  | i_s_tvalid/o_s_tready | i_s_tuser op, i_s_tdata key, hash, position
// m (res)  | out | o_m_tvalid/i_m_tready | o_m_tdata status, found, key_out, count
//
// Test and add probe slot by slot (a read then a check state each); clear clears every slot.
// Remove on a hit adds a clearing pass over every slot and re-places every kept key
// from the order list, probing each the same way; the registered slot RAM read sets this.
// After reset a clearing pass over every slot runs before the first word is taken.
// A finished result waits in the output register; a new word is taken meanwhile.
// Top level of the hash set; depends on lphs_pkg, lphs_ctrl, lphs_dp, lphs_ram.
module linear_probe_hash_set_core #(
    parameter int SLOTS    = 64,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // key[31:0], key_hash[63:32], position[69:64], zero pad
    input  logic [2:0]  i_s_tuser,  // op[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata   // status[1:0], found[2], key_out[34:3], count[40:35], pad
);
    lphs_pkg::t_cmd  cmd;
    lphs_pkg::t_stat stat;
    logic [1:0]  res_status;
    logic        res_found;
    logic [31:0] res_key_out;
    logic [5:0]  res_count;

    lphs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lphs_dp #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_op      (i_s_tuser),
        .i_key     (i_s_tdata[31:0]),
        .i_hash    (i_s_tdata[63:32]),
        .i_pos     (i_s_tdata[69:64]),
        .o_status  (res_status),
        .o_found   (res_found),
        .o_key_out (res_key_out),
        .o_count   (res_count)
    );

    assign o_m_tdata = {7'd0, res_count, res_key_out, res_found, res_status};

`ifndef ASSERT_OFF
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !o_s_tready)
        else $error("ready during clearing pass");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second word taken while busy");
    a_kout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[2]) |-> (o_m_tdata[34:3] == 32'd0))
        else $error("key_out set without found");
    a_full_nf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] == lphs_pkg::RS_FULL) |-> !o_m_tdata[2])
        else $error("full status with found");
`endif
endmodule

FILE: sim/tb_linear_probe_hash_set_core.sv
`timescale 1ns / 100ps
// Testbench for linear_probe_hash_set_core: a scoreboard of the set predicts each result word.
// Depends on lphs_pkg and the core RTL.
module tb_linear_probe_hash_set_core;

    localparam int NSLOT = 64;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] hash;
        logic [5:0]  pos;
    } t_req;

    // lowest field last so the layout matches o_m_tdata
    typedef struct packed {
        logic [5:0]  count;
        logic [31:0] key_out;
        logic        found;
        logic [1:0]  status;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;
    logic [2:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;

    linear_probe_hash_set_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    // predicted set contents
    logic        sl_used [NSLOT];
    logic [31:0] sl_hash [NSLOT];
    logic [31:0] sl_key  [NSLOT];
    logic [31:0] ord_key [NSLOT];
    logic [31:0] ord_hash[NSLOT];
    int unsigned n_keys;

    t_req pending_q[$];
    t_res expected_q[$];
    int   errors;
    int   src_idle_pct, snk_idle_pct;
    bit   hold_src;
    bit   stim_done;

    // word pools so random keys collide with held ones
    logic [31:0] pool_key[$];
    logic [31:0] pool_hash[$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int find_slot(logic [31:0] k, logic [31:0] h);
        int idx;
        idx = h[5:0];
        for (int n = 0; n < NSLOT && sl_used[idx]; n++) begin
            if (sl_hash[idx] == h && sl_key[idx] == k) return idx;
            idx = (idx + 1) % NSLOT;
        end
        return -1;
    endfunction

    function automatic void place_key(logic [31:0] k, logic [31:0] h);
        int idx;
        idx = h[5:0];
        for (int n = 0; n < NSLOT; n++) begin
            if (!sl_used[idx]) begin
                sl_used[idx] = 1'b1;
                sl_hash[idx] = h;
                sl_key[idx]  = k;
                ord_key[n_keys]  = k;
                ord_hash[n_keys] = h;
                n_keys++;
                return;
            end
            idx = (idx + 1) % NSLOT;
        end
    endfunction

    function automatic t_res apply_op(t_req r);
        t_res        res;
        logic [31:0] tk[NSLOT];
        logic [31:0] th[NSLOT];
        int unsigned n;
        res = '{status: lphs_pkg::RS_MISS, found: 1'b0, key_out: '0, count: '0};
        case (r.op)
            lphs_pkg::OP_ADD: begin
                if (find_slot(r.key, r.hash) >= 0) begin
                    res.status = lphs_pkg::RS_UPD;
                    res.found  = 1'b1;
                end else if ((n_keys + 1) * 4 > NSLOT * 3) begin
                    res.status = lphs_pkg::RS_FULL;
                end else begin
                    place_key(r.key, r.hash);
                    res.status = lphs_pkg::RS_DONE;
                end
            end
            lphs_pkg::OP_TEST: begin
                if (find_slot(r.key, r.hash) >= 0) begin
                    res.status = lphs_pkg::RS_DONE;
                    res.found  = 1'b1;
                end
            end
            lphs_pkg::OP_REM: begin
                if (find_slot(r.key, r.hash) >= 0) begin
                    n = n_keys;
                    tk = ord_key;
                    th = ord_hash;
                    for (int i = 0; i < NSLOT; i++) sl_used[i] = 1'b0;
                    n_keys = 0;
                    for (int i = 0; i < n; i++)
                        if (tk[i] != r.key && find_slot(tk[i], th[i]) < 0)
                            place_key(tk[i], th[i]);
                    res.status = lphs_pkg::RS_DONE;
                    res.found  = 1'b1;
                end
            end
            lphs_pkg::OP_READ: begin
                if (r.pos < n_keys) begin
                    res.status  = lphs_pkg::RS_DONE;
                    res.found   = 1'b1;
                    res.key_out = ord_key[r.pos];
                end
            end
            lphs_pkg::OP_CLEAR: begin
                for (int i = 0; i < NSLOT; i++) sl_used[i] = 1'b0;
                n_keys = 0;
                res.status = lphs_pkg::RS_DONE;
            end
            default: ;
        endcase
        res.count = n_keys[5:0];
        return res;
    endfunction

    function automatic t_req mk(logic [2:0] op, logic [31:0] k, logic [31:0] h,
                                logic [5:0] p);
        t_req r;
        r.op = op; r.key = k; r.hash = h; r.pos = p;
        return r;
    endfunction

    // random item: mostly keys from a small pool with clustered hashes
    function automatic t_req rand_req();
        t_req r;
        int   sel, roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)      r.op = lphs_pkg::OP_ADD;
        else if (roll < 65) r.op = lphs_pkg::OP_TEST;
        else if (roll < 82) r.op = lphs_pkg::OP_REM;
        else if (roll < 95) r.op = lphs_pkg::OP_READ;
        else if (roll < 97) r.op = lphs_pkg::OP_CLEAR;
        else                r.op = 3'($urandom_range(5, 7));
        sel = $urandom_range(0, pool_key.size() - 1);
        r.key  = pool_key[sel];
        r.hash = pool_hash[sel];
        if ($urandom_range(0, 9) == 0) r.key = $urandom();
        if ($urandom_range(0, 9) == 0) r.hash = $urandom();
        r.pos = 6'($urandom());
        if (r.pos > n_keys + 2 && $urandom_range(0, 3) != 0)
            r.pos = 6'($urandom_range(0, n_keys + 1));
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_q.size() != 0 && !hold_src
                    && $urandom_range(0, 99) >= src_idle_pct) begin
                t_req r;
                r = pending_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= r.op;
                i_s_tdata  <= {2'b0, r.pos, r.hash, r.key};
                expected_q.push_back(apply_op(r));
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor, receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                t_res got, exp_r;
                got = o_m_tdata[40:0];
                if (expected_q.size() == 0) begin
                    $display("%0t: result word with none expected, got %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.status !== exp_r.status || got.found !== exp_r.found
                            || got.key_out !== exp_r.key_out || got.count !== exp_r.count) begin
                        $display("%0t: mismatch exp st=%0d f=%0d k=%h c=%0d got st=%0d f=%0d k=%h c=%0d",
                                 $time, exp_r.status, exp_r.found, exp_r.key_out, exp_r.count,
                                 got.status, got.found, got.key_out, got.count);
                        errors++;
                    end
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial begin
        #100_000_000;
        $display("tb_linear_probe_hash_set_core NOT OK");
        $finish;
    end

    task automatic wait_drain();
        while (pending_q.size() != 0 || i_s_tvalid || expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        errors = 0;
        hold_src = 1'b0;
        stim_done = 1'b0;
        src_idle_pct = 21;
        snk_idle_pct = 77;
        n_keys = 0;
        for (int i = 0; i < NSLOT; i++) sl_used[i] = 1'b0;
        for (int i = 0; i < 24; i++) begin
            pool_key.push_back($urandom());
            // few home slots so probe chains wrap and cluster
            pool_hash.push_back({$urandom_range(0, 3) == 0 ? 26'($urandom()) : 26'd0,
                                 6'($urandom_range(60, 63) + (i % 3) * 5)});
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every op, special cases
        pending_q.push_back(mk(lphs_pkg::OP_READ, '0, '0, 6'd0));
        pending_q.push_back(mk(lphs_pkg::OP_TEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
        pending_q.push_back(mk(lphs_pkg::OP_REM, 32'h1, 32'h1, 6'd0));
        pending_q.push_back(mk(lphs_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
        pending_q.push_back(mk(lphs_pkg::OP_ADD, 32'h0, 32'h0, 6'd0));
        pending_q.push_back(mk(lphs_pkg::OP_ADD, 32'h0, 32'h0, 6'd0));
        pending_q.push_back(mk(lphs_pkg::OP_ADD, 32'h0, 32'h40, 6'd0));   // same key, other hash
        pending_q.push_back(mk(lphs_pkg::OP_ADD, 32'h5, 32'h3F, 6'd0));   // wraps past last slot
        pending_q.push_back(mk(lphs_pkg::OP_TEST, 32'h0, 32'h40, 6'd0));
        pending_q.push_back(mk(lphs_pkg::OP_READ, '0, '0, 6'd3));
        pending_q.push_back(mk(lphs_pkg::OP_READ, '0, '0, 6'd4));
        pending_q.push_back(mk(lphs_pkg::OP_REM, 32'h0, 32'h0, 6'd0));    // drops both entries
        pending_q.push_back(mk(lphs_pkg::OP_READ, '0, '0, 6'd1));
        pending_q.push_back(mk(3'd5, 32'h5, 32'h3F, 6'd0));
        pending_q.push_back(mk(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
        pending_q.push_back(mk(lphs_pkg::OP_CLEAR, '0, '0, 6'd0));
        wait_drain();
        // fill to the load limit, then refuse, then update at the limit
        for (int i = 0; i < 50; i++)
            pending_q.push_back(mk(lphs_pkg::OP_ADD, 32'(i * 7 + 1), 32'(i % 5), 6'd0));
        pending_q.push_back(mk(lphs_pkg::OP_ADD, 32'd1, 32'd0, 6'd0));
        pending_q.push_back(mk(lphs_pkg::OP_READ, '0, '0, 6'd47));
        pending_q.push_back(mk(lphs_pkg::OP_REM, 32'd8, 32'd1, 6'd0));
        pending_q.push_back(mk(lphs_pkg::OP_CLEAR, '0, '0, 6'd0));
        wait_drain();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 77 : 0;
            snk_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 21 : 0;
            for (int i = 0; i < 235; i++) begin
                // predictor state moves at drive time; items are shaped off it when queued
                pending_q.push_back(rand_req());
                if (pending_q.size() > 4) @(posedge i_clk);
                while (pending_q.size() > 4) @(posedge i_clk);
            end
            // send what is queued, then hold the sender until every result is back
            while (pending_q.size() != 0) @(posedge i_clk);
            hold_src = 1'b1;
            wait_drain();
            hold_src = 1'b0;
        end
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb_linear_probe_hash_set_core OK");
        else
            $display("tb_linear_probe_hash_set_core NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
src/lphs_pkg.sv
src/lphs_ram.sv
src/lphs_dp.sv
src/lphs_ctrl.sv
src/linear_probe_hash_set_core.sv
sim/tb_linear_probe_hash_set_core.sv
